// ===== hdl/cau_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

    localparam int OPW      = 16;  // Q8.8 operand width
    localparam int RESW     = 32;  // Q16.16 result width
    localparam int RAWW     = 34;  // unsaturated result width
    localparam int QDEPTH   = 4;   // front-to-back queue depth
    localparam int QPTRW    = 2;   // queue pointer width
    localparam int DIVSTEPS = 32;  // quotient bits, one per pipeline stage

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    // Item class decided by the front end
    typedef enum logic [2:0] {
        CL_ADD  = 3'd0,
        CL_SUB  = 3'd1,
        CL_MUL  = 3'd2,
        CL_DIV  = 3'd3,
        CL_DIVZ = 3'd4
    } cls_t;

    typedef struct packed {
        cls_t                  cls;
        logic signed [OPW-1:0] ar;
        logic signed [OPW-1:0] ai;
        logic signed [OPW-1:0] br;
        logic signed [OPW-1:0] bi;
    } item_t;

    // Queue occupancy seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== hdl/cau_front.sv =====
// Front end: takes input transactions and classifies them.
module cau_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    op,
    input  logic signed [15:0]            a_real,
    input  logic signed [15:0]            a_imag,
    input  logic signed [15:0]            b_real,
    input  logic signed [15:0]            b_imag,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cau_pkg::q_stat_t              q_stat,
    output logic                          push,
    output cau_pkg::item_t                item
);
    import cau_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    assign push     = vld_reg && !q_stat.full;
    assign in_ready = !vld_reg || !q_stat.full;
    assign take     = in_valid && in_ready;
    assign item     = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (push)
        begin
            vld_next = 1'b0;
        end
    end

    always_comb
    begin
        item_next.ar = a_real;
        item_next.ai = a_imag;
        item_next.br = b_real;
        item_next.bi = b_imag;
        unique case (op_t'(op))
            OP_ADD: item_next.cls = CL_ADD;
            OP_SUB: item_next.cls = CL_SUB;
            OP_MUL: item_next.cls = CL_MUL;
            OP_DIV: item_next.cls = (b_real == '0 && b_imag == '0) ? CL_DIVZ : CL_DIV;
            default: item_next.cls = CL_ADD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hdl/cau_queue.sv =====
// Small FIFO between the front end and the execution pipeline.
module cau_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cau_pkg::item_t     push_item,
    input  logic               pop,
    output cau_pkg::item_t     head,
    output cau_pkg::q_stat_t   q_stat
);
    import cau_pkg::*;

    item_t             store [QDEPTH];
    logic [QPTRW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTRW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTRW:0]    count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == (QPTRW+1)'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTRW+1)'(QDEPTH))
        else $error("queue count over depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full && !pop |=> q_stat.full)
        else $error("queue lost entries while full");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> rd_ptr_reg == $past(rd_ptr_reg) + 1'b1)
        else $error("read pointer did not advance on pop");
`endif

endmodule

// ===== hdl/cau_back.sv =====
// Execution pipeline: products, sums, 32-stage divider, saturation, output register.
module cau_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cau_pkg::item_t         head,
    input  cau_pkg::q_stat_t       q_stat,
    output logic                   pop,
    output logic signed [31:0]     res_real,
    output logic signed [31:0]     res_imag,
    output logic [1:0]             status,
    output logic                   out_valid,
    input  logic                   out_ready
);
    import cau_pkg::*;

    typedef struct packed {
        cls_t                   cls;
        logic signed [RAWW-1:0] raw_re;
        logic signed [RAWW-1:0] raw_im;
        logic                   neg_re;
        logic                   neg_im;
        logic                   big_re;
        logic                   big_im;
        logic [31:0]            den;
        logic [31:0]            rem_re;
        logic [31:0]            w_re;
        logic [31:0]            rem_im;
        logic [31:0]            w_im;
    } dstage_t;

    // One restoring-division step: {remainder, dividend/quotient shift word}
    function automatic logic [63:0] div_step(input logic [31:0] rem,
                                             input logic [31:0] w,
                                             input logic [31:0] den);
        logic [32:0] trial;
        logic [32:0] diff;
        trial = {rem, w[31]};
        diff  = trial - {1'b0, den};
        if (!diff[32])
        begin
            div_step = {diff[31:0], w[30:0], 1'b1};
        end
        else
        begin
            div_step = {trial[31:0], w[30:0], 1'b0};
        end
    endfunction

    function automatic logic [32:0] sat32(input logic signed [RAWW-1:0] v);
        logic ovf;
        ovf = !((v[RAWW-1:RESW-1] == '0) || (v[RAWW-1:RESW-1] == '1));
        if (ovf)
        begin
            sat32 = {1'b1, v[RAWW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        else
        begin
            sat32 = {1'b0, v[RESW-1:0]};
        end
    endfunction

    logic en;

    // stage 1: products
    logic                   s1_vld_reg;
    cls_t                   s1_cls_reg;
    logic signed [31:0]     p_arbr_reg, p_aibi_reg, p_arbi_reg, p_aibr_reg;
    logic signed [31:0]     p_brbr_reg, p_bibi_reg;
    logic signed [16:0]     s1_sre_reg, s1_sim_reg;
    logic signed [16:0]     sre_next, sim_next;

    // stage 2: sums
    logic                   s2_vld_reg;
    cls_t                   s2_cls_reg;
    logic signed [RAWW-1:0] s2_raw_re_reg, s2_raw_im_reg;
    logic signed [RAWW-1:0] raw_re_next, raw_im_next;
    logic signed [32:0]     nre_reg, nim_reg;
    logic [31:0]            den_reg;

    // divider stages
    logic                   dvld_reg [DIVSTEPS+1];
    dstage_t                dst_reg  [DIVSTEPS+1];
    dstage_t                d0_next;
    logic [32:0]            mag_re_w, mag_im_w;

    // output
    logic                   out_vld_reg;
    logic signed [31:0]     res_re_reg, res_im_reg;
    logic [1:0]             status_reg;
    logic signed [31:0]     res_re_next, res_im_next;
    logic [1:0]             status_next;
    logic signed [RAWW-1:0] fin_re, fin_im;
    logic [32:0]            sat_re, sat_im;
    dstage_t                last;

    assign en        = !out_vld_reg || out_ready;
    assign pop       = en;
    assign out_valid = out_vld_reg;
    assign res_real  = res_re_reg;
    assign res_imag  = res_im_reg;
    assign status    = status_reg;

    // stage 1 add/subtract
    always_comb
    begin
        if (head.cls == CL_SUB)
        begin
            sre_next = 17'(head.ar) - 17'(head.br);
            sim_next = 17'(head.ai) - 17'(head.bi);
        end
        else
        begin
            sre_next = 17'(head.ar) + 17'(head.br);
            sim_next = 17'(head.ai) + 17'(head.bi);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cls_reg <= head.cls;
            p_arbr_reg <= head.ar * head.br;
            p_aibi_reg <= head.ai * head.bi;
            p_arbi_reg <= head.ar * head.bi;
            p_aibr_reg <= head.ai * head.br;
            p_brbr_reg <= head.br * head.br;
            p_bibi_reg <= head.bi * head.bi;
            s1_sre_reg <= sre_next;
            s1_sim_reg <= sim_next;
        end
    end

    // stage 2
    always_comb
    begin
        if (s1_cls_reg == CL_MUL)
        begin
            raw_re_next = RAWW'(p_arbr_reg) - RAWW'(p_aibi_reg);
            raw_im_next = RAWW'(p_arbi_reg) + RAWW'(p_aibr_reg);
        end
        else
        begin
            raw_re_next = {{9{s1_sre_reg[16]}}, s1_sre_reg, 8'h00};
            raw_im_next = {{9{s1_sim_reg[16]}}, s1_sim_reg, 8'h00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_cls_reg    <= s1_cls_reg;
            s2_raw_re_reg <= raw_re_next;
            s2_raw_im_reg <= raw_im_next;
            nre_reg       <= 33'(p_arbr_reg) + 33'(p_aibi_reg);
            nim_reg       <= 33'(p_aibr_reg) - 33'(p_arbi_reg);
            den_reg       <= $unsigned(p_brbr_reg) + $unsigned(p_bibi_reg);
        end
    end

    // stage 3: magnitudes, overflow precheck, divider seed
    always_comb
    begin
        mag_re_w       = nre_reg[32] ? -nre_reg : nre_reg;
        mag_im_w       = nim_reg[32] ? -nim_reg : nim_reg;
        d0_next.cls    = s2_cls_reg;
        d0_next.raw_re = s2_raw_re_reg;
        d0_next.raw_im = s2_raw_im_reg;
        d0_next.neg_re = nre_reg[32];
        d0_next.neg_im = nim_reg[32];
        d0_next.big_re = {15'h0, mag_re_w} >= {den_reg, 16'h0};
        d0_next.big_im = {15'h0, mag_im_w} >= {den_reg, 16'h0};
        d0_next.den    = den_reg;
        d0_next.rem_re = {16'h0, mag_re_w[31:16]};
        d0_next.w_re   = {mag_re_w[15:0], 16'h0};
        d0_next.rem_im = {16'h0, mag_im_w[31:16]};
        d0_next.w_im   = {mag_im_w[15:0], 16'h0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dst_reg[0] <= d0_next;
        end
    end

    for (genvar k = 1; k <= DIVSTEPS; k++)
    begin : g_div
        logic [63:0] st_re, st_im;
        dstage_t     nxt;

        always_comb
        begin
            st_re      = div_step(dst_reg[k-1].rem_re, dst_reg[k-1].w_re, dst_reg[k-1].den);
            st_im      = div_step(dst_reg[k-1].rem_im, dst_reg[k-1].w_im, dst_reg[k-1].den);
            nxt        = dst_reg[k-1];
            nxt.rem_re = st_re[63:32];
            nxt.w_re   = st_re[31:0];
            nxt.rem_im = st_im[63:32];
            nxt.w_im   = st_im[31:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dst_reg[k] <= nxt;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dvld_reg[k] <= dvld_reg[k-1];
            end
        end
    end

    // final: sign, saturation, status
    assign last = dst_reg[DIVSTEPS];

    always_comb
    begin
        if (last.cls == CL_DIV)
        begin
            if (last.big_re)
            begin
                fin_re = last.neg_re ? {1'b1, {(RAWW-1){1'b0}}} : {1'b0, {(RAWW-1){1'b1}}};
            end
            else
            begin
                fin_re = last.neg_re ? -RAWW'({1'b0, last.w_re}) : RAWW'({1'b0, last.w_re});
            end
            if (last.big_im)
            begin
                fin_im = last.neg_im ? {1'b1, {(RAWW-1){1'b0}}} : {1'b0, {(RAWW-1){1'b1}}};
            end
            else
            begin
                fin_im = last.neg_im ? -RAWW'({1'b0, last.w_im}) : RAWW'({1'b0, last.w_im});
            end
        end
        else
        begin
            fin_re = last.raw_re;
            fin_im = last.raw_im;
        end
        sat_re = sat32(fin_re);
        sat_im = sat32(fin_im);
        if (last.cls == CL_DIVZ)
        begin
            res_re_next = '0;
            res_im_next = '0;
            status_next = ST_DIVZ;
        end
        else
        begin
            res_re_next = sat_re[31:0];
            res_im_next = sat_im[31:0];
            status_next = (sat_re[32] || sat_im[32]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            dvld_reg[0] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= !q_stat.empty;
            s2_vld_reg  <= s1_vld_reg;
            dvld_reg[0] <= s2_vld_reg;
            out_vld_reg <= dvld_reg[DIVSTEPS];
        end
    end

`ifndef SYNTH
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && status_reg == ST_DIVZ |-> res_re_reg == '0 && res_im_reg == '0)
        else $error("divide by zero with nonzero result");
    a_tail_moves: assert property (@(posedge clk) disable iff (!rst_n)
        en && dvld_reg[DIVSTEPS] |=> out_vld_reg)
        else $error("last divider stage lost a transaction");
    a_feed: assert property (@(posedge clk) disable iff (!rst_n)
        en && !q_stat.empty |=> s1_vld_reg)
        else $error("popped transaction not in stage 1");
`endif

endmodule

// ===== hdl/complex_arith_unit.sv =====
// Top level of the complex arithmetic unit.
// Complex ALU on two signed Q8.8 operands: add, subtract, multiply or divide,
// giving a signed Q16.16 result pair and a status (0 ok, 1 divide by zero,
// 2 saturated). A front register takes the input transaction and classifies
// it (including the zero-divisor case); a 4-entry queue decouples it from the
// execution pipeline. The pipeline is fully pipelined: one transaction per
// cycle sustained while out_ready does not hold it. A transaction passes the
// front register (loaded on acceptance), a queue entry, three arithmetic
// stages, 32 restoring-division stages (one quotient bit per stage) and
// the output register; every operation travels the same path so results
// leave in order. A divide quotient truncates toward zero; any part outside
// Q16.16 clamps to the nearest limit. The pipeline holds as a whole while
// out_valid is high and out_ready is low; the queue and front register
// keep taking input until they fill.
module complex_arith_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         op,
    input  logic signed [15:0] a_real,
    input  logic signed [15:0] a_imag,
    input  logic signed [15:0] b_real,
    input  logic signed [15:0] b_imag,
    input  logic               in_valid,
    output logic               in_ready,
    output logic signed [31:0] res_real,
    output logic signed [31:0] res_imag,
    output logic [1:0]         status,
    output logic               out_valid,
    input  logic               out_ready
);
    import cau_pkg::*;

    item_t   fe_item;
    item_t   q_head;
    q_stat_t q_stat;
    logic    fe_push;
    logic    be_pop;

    // classify and hold one transaction
    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .a_real   (a_real),
        .a_imag   (a_imag),
        .b_real   (b_real),
        .b_imag   (b_imag),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_stat   (q_stat),
        .push     (fe_push),
        .item     (fe_item)
    );

    // decoupling queue
    cau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_push),
        .push_item (fe_item),
        .pop       (be_pop),
        .head      (q_head),
        .q_stat    (q_stat)
    );

    // execution pipeline and output register
    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .pop       (be_pop),
        .res_real  (res_real),
        .res_imag  (res_imag),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule
